FILE: hdl/mlt_pkg.sv
// ----------------------------------------------------------------------------
// mlt_pkg
// Shared types, widths and helpers for the MAC/IP learning table.
// ----------------------------------------------------------------------------
package mlt_pkg;

    localparam int MAC_W       = 48;
    localparam int IP_W        = 32;
    localparam int TS_W        = 32;
    localparam int BUCKET_W    = 8;
    localparam int WAY_OUT_W   = 2;
    localparam int IN_TDATA_W  = 112;
    localparam int OUT_TDATA_W = 48;

    localparam int HASH_BUCKETS     = 256;
    localparam int BUCKET_WAYS_DEF  = 4;

    typedef struct packed {
        logic             valid;
        logic [MAC_W-1:0] mac;
        logic [IP_W-1:0]  ip;
        logic [TS_W-1:0]  first_seen;
        logic [TS_W-1:0]  last_seen;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef enum logic [1:0] {
        STATUS_IGNORED   = 2'd0,
        STATUS_REFRESHED = 2'd1,
        STATUS_ADDED     = 2'd2,
        STATUS_DROPPED   = 2'd3
    } t_status;

    // Lookup verdict handed back to the control logic
    typedef struct packed {
        logic                 we;
        t_status              status;
        logic [WAY_OUT_W-1:0] way;
        logic [TS_W-1:0]      first_seen;
    } t_lookup_res;

    function automatic logic [BUCKET_W-1:0] mac_hash(input logic [MAC_W-1:0] mac);
        return mac[47:40] ^ mac[39:32] ^ mac[31:24] ^ mac[23:16] ^ mac[15:8] ^ mac[7:0];
    endfunction

endpackage

FILE: hdl/mlt_ram.sv
// ----------------------------------------------------------------------------
// mlt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/mlt_lookup.sv
// ----------------------------------------------------------------------------
// mlt_lookup
// Searches one bucket row for the MAC/IP pair, picks the hit or the lowest
// free way, and builds the row to write back.
// ----------------------------------------------------------------------------
module mlt_lookup #(
    parameter int BUCKET_WAYS = mlt_pkg::BUCKET_WAYS_DEF
) (
    input  logic [BUCKET_WAYS*mlt_pkg::ENTRY_W-1:0] i_row,
    input  logic [mlt_pkg::MAC_W-1:0]               i_mac,
    input  logic [mlt_pkg::IP_W-1:0]                i_ip,
    input  logic [mlt_pkg::TS_W-1:0]                i_ts,
    output mlt_pkg::t_lookup_res                    o_res,
    output logic [BUCKET_WAYS*mlt_pkg::ENTRY_W-1:0] o_row
);

    localparam int ENTRY_W = mlt_pkg::ENTRY_W;
    localparam int WAY_W   = (BUCKET_WAYS > 1) ? $clog2(BUCKET_WAYS) : 1;

    mlt_pkg::t_entry         ent [BUCKET_WAYS];
    logic                    ignore;
    logic                    hit;
    logic                    free_found;
    logic [WAY_W-1:0]        hit_way;
    logic [WAY_W-1:0]        free_way;
    logic [WAY_W-1:0]        sel_way;
    logic [mlt_pkg::TS_W-1:0] hit_first;
    logic [31:0]             way_ext;

    assign ignore = (i_mac == '1) || (i_mac == '0);

    always_comb begin
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            ent[w] = mlt_pkg::t_entry'(i_row[w*ENTRY_W +: ENTRY_W]);
        end
    end

    // first matching way wins; first empty way is the fill candidate
    always_comb begin
        hit        = 1'b0;
        free_found = 1'b0;
        hit_way    = '0;
        free_way   = '0;
        hit_first  = '0;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            if (ent[w].valid) begin
                if (!hit && ent[w].mac == i_mac && ent[w].ip == i_ip) begin
                    hit       = 1'b1;
                    hit_way   = WAY_W'(w);
                    hit_first = ent[w].first_seen;
                end
            end else if (!free_found) begin
                free_found = 1'b1;
                free_way   = WAY_W'(w);
            end
        end
    end

    assign sel_way = hit ? hit_way : free_way;
    assign way_ext = 32'(sel_way);

    always_comb begin
        mlt_pkg::t_entry rec;
        o_row = i_row;
        for (int w = 0; w < BUCKET_WAYS; w++) begin
            rec           = ent[w];
            rec.last_seen = i_ts;
            if (!hit) begin
                rec.valid      = 1'b1;
                rec.mac        = i_mac;
                rec.ip         = i_ip;
                rec.first_seen = i_ts;
            end
            if (WAY_W'(w) == sel_way) begin
                o_row[w*ENTRY_W +: ENTRY_W] = rec;
            end
        end
    end

    always_comb begin
        o_res.we         = 1'b0;
        o_res.status     = mlt_pkg::STATUS_IGNORED;
        o_res.way        = '0;
        o_res.first_seen = '0;
        if (!ignore) begin
            if (hit) begin
                o_res.we         = 1'b1;
                o_res.status     = mlt_pkg::STATUS_REFRESHED;
                o_res.way        = way_ext[mlt_pkg::WAY_OUT_W-1:0];
                o_res.first_seen = hit_first;
            end else if (free_found) begin
                o_res.we         = 1'b1;
                o_res.status     = mlt_pkg::STATUS_ADDED;
                o_res.way        = way_ext[mlt_pkg::WAY_OUT_W-1:0];
                o_res.first_seen = i_ts;
            end else begin
                o_res.status     = mlt_pkg::STATUS_DROPPED;
            end
        end
    end

endmodule

FILE: hdl/mac_ip_learning_table_unit.sv
// ----------------------------------------------------------------------------
// mac_ip_learning_table_unit
// Learns MAC/IPv4 pairs into a hashed, set-associative table.
// ----------------------------------------------------------------------------
// Each input word carries one observed (MAC, IPv4, timestamp) triple and
// yields exactly one result word. The bucket is the XOR of the six MAC bytes;
// the whole bucket (BUCKET_WAYS entries plus valid bits) is one row of a
// single RAM, read, updated and written back. The accept cycle issues the row
// read; the lookup state then evaluates and writes back once the result
// register has room, so no new word is taken until the last one is finished.
// After reset the block sweeps the 256 rows to clear the valid bits;
// tready stays low until the sweep is done.
// ----------------------------------------------------------------------------
module mac_ip_learning_table_unit #(
    parameter int BUCKET_WAYS = mlt_pkg::BUCKET_WAYS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // mac_address[47:0], ip_address[79:48], timestamp[111:80]
    input  logic [mlt_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // status[1:0], bucket_index[9:2], way_index[11:10], first_seen[43:12], zero
    output logic [mlt_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);

    localparam int ROW_W = BUCKET_WAYS * mlt_pkg::ENTRY_W;
    localparam int PAD_W = mlt_pkg::OUT_TDATA_W - 2 - mlt_pkg::BUCKET_W
                           - mlt_pkg::WAY_OUT_W - mlt_pkg::TS_W;

    mlt_pkg::t_state                 r_state, n_state;
    logic [mlt_pkg::BUCKET_W-1:0]    r_clr_addr;
    logic [mlt_pkg::MAC_W-1:0]       r_mac;
    logic [mlt_pkg::IP_W-1:0]        r_ip;
    logic [mlt_pkg::TS_W-1:0]        r_ts;
    logic [mlt_pkg::BUCKET_W-1:0]    r_bucket;
    logic                            r_out_valid;
    logic [mlt_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic                            s_accept;
    logic                            out_load;
    logic                            ram_we;
    logic [mlt_pkg::BUCKET_W-1:0]    ram_waddr;
    logic [ROW_W-1:0]                ram_wdata;
    logic [mlt_pkg::BUCKET_W-1:0]    ram_raddr;
    logic [ROW_W-1:0]                ram_rdata;
    logic [ROW_W-1:0]                upd_row;
    mlt_pkg::t_lookup_res            lk_res;

    mlt_ram #(
        .WIDTH (ROW_W),
        .DEPTH (mlt_pkg::HASH_BUCKETS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (s_accept),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    mlt_lookup #(
        .BUCKET_WAYS (BUCKET_WAYS)
    ) u_lookup (
        .i_row (ram_rdata),
        .i_mac (r_mac),
        .i_ip  (r_ip),
        .i_ts  (r_ts),
        .o_res (lk_res),
        .o_row (upd_row)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            mlt_pkg::ST_CLEAR: begin
                if (r_clr_addr == '1) begin
                    n_state = mlt_pkg::ST_IDLE;
                end
            end
            mlt_pkg::ST_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = mlt_pkg::ST_LOOKUP;
                end
            end
            mlt_pkg::ST_LOOKUP: begin
                if (!r_out_valid || i_m_tready) begin
                    n_state = mlt_pkg::ST_IDLE;
                end
            end
            default: n_state = mlt_pkg::ST_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        out_load   = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = r_bucket;
        ram_wdata  = upd_row;
        case (r_state)
            mlt_pkg::ST_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_addr;
                ram_wdata = '0;
            end
            mlt_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            mlt_pkg::ST_LOOKUP: begin
                // row read data holds until the result register has room
                out_load = !r_out_valid || i_m_tready;
                ram_we   = out_load && lk_res.we;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    assign s_accept  = i_s_tvalid && o_s_tready;
    assign ram_raddr = mlt_pkg::mac_hash(i_s_tdata[47:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mlt_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == mlt_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mac    <= i_s_tdata[47:0];
            r_ip     <= i_s_tdata[79:48];
            r_ts     <= i_s_tdata[111:80];
            r_bucket <= ram_raddr;
        end
        if (out_load) begin
            r_out_data <= {{PAD_W{1'b0}}, lk_res.first_seen, lk_res.way,
                           r_bucket, lk_res.status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

`ifndef SYNTHESIS
    // one item in flight: no accept on the cycle after an accept
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("accept directly after accept");

    // table writes only come from the sweep or a lookup commit
    a_write_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == mlt_pkg::ST_CLEAR || out_load))
        else $error("table write outside sweep or commit");

    // broadcast and zero MACs always report ignored
    a_ignored_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && (r_mac == '0 || r_mac == '1))
        |=> (o_m_tdata[1:0] == mlt_pkg::STATUS_IGNORED))
        else $error("ignored MAC not reported as ignored");

    // a result is only produced after an accepted word
    a_result_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> $past(s_accept) || $past(r_state == mlt_pkg::ST_LOOKUP))
        else $error("result without an accepted word");
`endif

endmodule

FILE: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Testbench for mac_ip_learning_table_unit.
// ----------------------------------------------------------------------------
// Drives observed (MAC, IPv4, timestamp) words into the learning table and
// checks every result word against a behavioral copy of the table kept in the
// testbench. Directed tests cover ignored MACs, adds, refreshes and bucket
// overflow. Random traffic aims at a handful of busy buckets so that refreshes,
// adds and drops all occur. Both sides idle in random bursts, and the result
// side is also held off for a long stretch while words keep arriving.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WAYS           = mlt_pkg::BUCKET_WAYS_DEF;
    localparam int TABLE_ENTRIES  = mlt_pkg::HASH_BUCKETS * WAYS;
    localparam int RX_HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 16;
    localparam int POOL_MAX       = 512;

    typedef struct packed {
        mlt_pkg::t_status                    status;
        logic [mlt_pkg::BUCKET_W-1:0]        bucket;
        logic [mlt_pkg::WAY_OUT_W-1:0]       way;
        logic [mlt_pkg::TS_W-1:0]            first_seen;
    } t_verdict;

    logic                            clk      = 1'b0;
    logic                            rst_n    = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    // mac_address[47:0], ip_address[79:48], timestamp[111:80]
    logic [mlt_pkg::IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    // status[1:0], bucket_index[9:2], way_index[11:10], first_seen[43:12], zero
    logic [mlt_pkg::OUT_TDATA_W-1:0] m_tdata;

    // behavioral copy of the table
    bit                          tbl_valid [TABLE_ENTRIES];
    logic [mlt_pkg::MAC_W-1:0]   tbl_mac   [TABLE_ENTRIES];
    logic [mlt_pkg::IP_W-1:0]    tbl_ip    [TABLE_ENTRIES];
    logic [mlt_pkg::TS_W-1:0]    tbl_first [TABLE_ENTRIES];
    logic [mlt_pkg::TS_W-1:0]    tbl_last  [TABLE_ENTRIES];

    t_verdict                    verdicts_due[$];
    logic [mlt_pkg::MAC_W-1:0]   pair_mac[$];
    logic [mlt_pkg::IP_W-1:0]    pair_ip[$];

    int  mismatches    = 0;
    int  quiet_cycles  = 0;
    int  hold_requests = 0;
    int  hold_served   = 0;
    int  hold_left     = 0;
    int  rx_stall_left = 0;
    bit  calm          = 1'b0;

    logic [mlt_pkg::BUCKET_W-1:0] busy_buckets[8] = '{8'h00, 8'hff, 8'h5a, 8'h13,
                                                      8'h80, 8'h01, 8'hc4, 8'h7e};

    mac_ip_learning_table_unit #(
        .BUCKET_WAYS(WAYS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [mlt_pkg::BUCKET_W-1:0] xor_fold(
        input logic [mlt_pkg::MAC_W-1:0] mac);
        logic [mlt_pkg::BUCKET_W-1:0] h;
        h = '0;
        for (int k = 0; k < 6; k++) h ^= mac[8*k +: 8];
        return h;
    endfunction

    // Applies one observation to the table copy and returns the result word.
    function automatic t_verdict learn_pair(input logic [mlt_pkg::MAC_W-1:0] mac,
                                            input logic [mlt_pkg::IP_W-1:0]  ip,
                                            input logic [mlt_pkg::TS_W-1:0]  ts);
        t_verdict v;
        int base;
        int hit;
        int free_way;
        int a;
        v.status     = mlt_pkg::STATUS_IGNORED;
        v.bucket     = xor_fold(mac);
        v.way        = '0;
        v.first_seen = '0;
        if (mac == '1 || mac == '0) return v;
        base     = int'(v.bucket) * WAYS;
        hit      = -1;
        free_way = -1;
        for (int w = 0; w < WAYS; w++) begin
            a = base + w;
            if (tbl_valid[a]) begin
                if (hit < 0 && tbl_mac[a] == mac && tbl_ip[a] == ip) hit = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (hit >= 0) begin
            a = base + hit;
            tbl_last[a]  = ts;
            v.status     = mlt_pkg::STATUS_REFRESHED;
            v.way        = hit[mlt_pkg::WAY_OUT_W-1:0];
            v.first_seen = tbl_first[a];
        end else if (free_way >= 0) begin
            a = base + free_way;
            tbl_valid[a] = 1'b1;
            tbl_mac[a]   = mac;
            tbl_ip[a]    = ip;
            tbl_first[a] = ts;
            tbl_last[a]  = ts;
            v.status     = mlt_pkg::STATUS_ADDED;
            v.way        = free_way[mlt_pkg::WAY_OUT_W-1:0];
            v.first_seen = ts;
        end else begin
            v.status = mlt_pkg::STATUS_DROPPED;
        end
        return v;
    endfunction

    // Random MAC whose byte XOR lands in the given bucket.
    function automatic logic [mlt_pkg::MAC_W-1:0] mac_in_bucket(
        input logic [mlt_pkg::BUCKET_W-1:0] bucket);
        logic [39:0] rest;
        rest = {8'($urandom), $urandom};
        return {bucket ^ xor_fold({8'h00, rest}), rest};
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatches++;
    endtask

    task automatic offer_observation(input logic [mlt_pkg::MAC_W-1:0] mac,
                                     input logic [mlt_pkg::IP_W-1:0]  ip,
                                     input logic [mlt_pkg::TS_W-1:0]  ts);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ts, ip, mac};
        do @(posedge clk); while (!s_tready);
        verdicts_due.push_back(learn_pair(mac, ip, ts));
        if (pair_mac.size() < POOL_MAX) begin
            pair_mac.push_back(mac);
            pair_ip.push_back(ip);
        end
    endtask

    task automatic stop_offering();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (verdicts_due.size() != 0) @(posedge clk);
    endtask

    task automatic test_ignored_macs();
        offer_observation('1, '1, '1);
        offer_observation('0, '0, '0);
        offer_observation('1, 32'h0a00_0001, 32'h0000_1000);
        offer_observation('0, 32'hffff_ffff, 32'h8000_0000);
        stop_offering();
    endtask

    task automatic test_add_and_refresh();
        logic [mlt_pkg::MAC_W-1:0] mac;
        mac = 48'h0011_2233_4455;
        offer_observation(mac, 32'hc0a8_0001, 32'h0000_0010);
        offer_observation(mac, 32'hc0a8_0001, 32'hffff_ffff);
        offer_observation(mac, 32'hc0a8_0001, 32'h0000_0000);
        // same MAC, other IP: a second entry in the same bucket
        offer_observation(mac, 32'hc0a8_0002, 32'h0000_0020);
        offer_observation(mac, 32'h0000_0000, 32'h0000_0030);
        offer_observation(mac, 32'hffff_ffff, 32'h0000_0040);
        // nonzero MAC hashing to bucket zero, and one hashing to bucket one
        offer_observation(48'h0101_0000_0000, 32'h0102_0304, 32'h0000_0050);
        offer_observation(48'hfeff_ffff_ffff, 32'h0506_0708, 32'h0000_0060);
        offer_observation(48'h0101_0000_0000, 32'h0102_0304, 32'h0000_0070);
        stop_offering();
    endtask

    task automatic test_bucket_overflow();
        logic [mlt_pkg::MAC_W-1:0] macs[WAYS+1];
        for (int i = 0; i <= WAYS; i++) macs[i] = mac_in_bucket(8'h3c);
        for (int i = 0; i <= WAYS; i++) offer_observation(macs[i], 32'h0a0a_0000 + i, 100 + i);
        offer_observation(macs[WAYS-1], 32'h0a0a_0000 + WAYS - 1, 32'h0000_0200);
        offer_observation(macs[0], 32'h0b0b_0b0b, 32'h0000_0201);
        stop_offering();
    endtask

    task automatic random_traffic(input int count);
        int done;
        int pick;
        int roll;
        logic [mlt_pkg::MAC_W-1:0] mac;
        logic [mlt_pkg::IP_W-1:0]  ip;
        logic [mlt_pkg::TS_W-1:0]  ts;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(0, 99);
            ts   = ($urandom_range(0, 49) == 0) ?
                   {mlt_pkg::TS_W{$urandom_range(0, 1) == 1}} : $urandom;
            ip   = $urandom;
            if (roll < 45 && pair_mac.size() != 0) begin
                pick = $urandom_range(0, pair_mac.size() - 1);
                mac  = pair_mac[pick];
                ip   = pair_ip[pick];
            end else if (roll < 70) begin
                mac = mac_in_bucket(busy_buckets[$urandom_range(0, 7)]);
            end else if (roll < 78 && pair_mac.size() != 0) begin
                mac = pair_mac[$urandom_range(0, pair_mac.size() - 1)];
            end else if (roll < 96) begin
                mac = {16'($urandom), $urandom};
            end else begin
                mac = ($urandom_range(0, 1) == 1) ? '1 : '0;
            end
            offer_observation(mac, ip, ts);
            if (mac != '1 && mac != '0) done++;
        end
        stop_offering();
    endtask

    // Result side held off while words keep coming, so the input stalls.
    task automatic test_result_backpressure();
        hold_requests <= hold_requests + 1;
        random_traffic(40);
        wait_drained();
    endtask

    // Sender pauses mid-stream until every result has come back.
    task automatic test_pause_until_drained();
        random_traffic(20);
        wait_drained();
        random_traffic(20);
    endtask

    task automatic test_steady_stream();
        calm <= 1'b1;
        random_traffic(100);
    endtask

    // Result side: random stall bursts, plus the long hold-off on request.
    always @(posedge clk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= RX_HOLD_CYCLES - 1;
            m_tready    <= 1'b0;
        end else if (rx_stall_left != 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= rx_stall_left - 1;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            m_tready      <= 1'b0;
            rx_stall_left <= $urandom_range(0, 5);
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        t_verdict want;
        if (rst_n && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch("unexpected result word", m_tdata[31:0], 32'h0);
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[1:0] != want.status)
                    report_mismatch("status", m_tdata[1:0], want.status);
                if (m_tdata[9:2] != want.bucket)
                    report_mismatch("bucket_index", m_tdata[9:2], want.bucket);
                if (m_tdata[11:10] != want.way)
                    report_mismatch("way_index", m_tdata[11:10], want.way);
                if (m_tdata[43:12] != want.first_seen)
                    report_mismatch("first_seen", m_tdata[43:12], want.first_seen);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        test_ignored_macs();
        test_add_and_refresh();
        test_bucket_overflow();
        test_result_backpressure();
        test_pause_until_drained();
        random_traffic(1600);
        test_steady_stream();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule
